FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL that checks its own logic; the FIFO core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checks that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/pdf_pkg.sv
// Package with the constants, codes and types of the priming delay FIFO.
package pdf_pkg;

    // Queue geometry.
    localparam int RING_SIZE   = 64;
    localparam int HANDLE_W    = 32;
    localparam int PTR_W       = $clog2(RING_SIZE);
    localparam int CNT_W       = $clog2(RING_SIZE + 1);

    // Configuration registers.
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CMP_W       = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
    localparam int CAP_HEADROOM = 10;
    localparam logic [CFG_W-1:0] DELAY_TARGET_RESET = 7'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_CAP    = 2'd1;

    // Operation codes.
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    // Status codes.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NOT_PRIMED = 2'd1;
    localparam logic [1:0] STATUS_UNDERRUN   = 2'd2;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

FILE: hw/rtl/pdf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module pdf_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/priming_delay_fifo_core.sv
// Top level of the priming delay FIFO: sequencer, ring state and result register.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         i_valid / o_ready         i_kind, i_block_handle
//   result   out        o_valid / i_ready         o_status ... o_pushed_total
//   config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An operation first takes the beat and reads the head entry from the entry memory;
// in the execute state the result is then computed and registered.
// A new beat is taken only in the idle state, once the previous operation has been registered.
// A stalled result holds in the output register; one more operation is taken and waits
// for it. Reset is synchronous and clears control state; the memory needs no clearing.
module priming_delay_fifo_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_kind,
    input  logic [pdf_pkg::HANDLE_W-1:0]     i_block_handle,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [1:0]                       o_status,
    output logic [pdf_pkg::HANDLE_W-1:0]     o_out_handle,
    output logic                             o_evicted_valid,
    output logic [pdf_pkg::HANDLE_W-1:0]     o_evicted_handle,
    output logic [pdf_pkg::CNT_W-1:0]        o_fill_level,
    output logic                             o_is_primed,
    output logic [pdf_pkg::CNT_W-1:0]        o_flushed_count,
    output logic [31:0]                      o_dropped_total,
    output logic [31:0]                      o_underrun_total,
    output logic [31:0]                      o_pushed_total,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pdf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pdf_pkg::CFG_W-1:0]        i_cfg_data
);

    // Sequencer and ring state.
    pdf_pkg::t_state                r_state, n_state;
    logic [pdf_pkg::PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [pdf_pkg::PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [pdf_pkg::CNT_W-1:0]      r_fill, n_fill;
    logic                           r_primed, n_primed;
    logic [31:0]                    r_drops, n_drops;
    logic [31:0]                    r_underruns, n_underruns;
    logic [31:0]                    r_pushes, n_pushes;
    logic [pdf_pkg::CFG_W-1:0]      r_delay_target;
    logic [pdf_pkg::CFG_W-1:0]      r_depth_cap;

    // Captured operation.
    logic [1:0]                     r_kind;
    logic [pdf_pkg::HANDLE_W-1:0]   r_handle;

    // Result register.
    logic                           r_out_valid, n_out_valid;
    logic [1:0]                     r_status, n_status;
    logic [pdf_pkg::HANDLE_W-1:0]   r_out_handle, n_out_handle;
    logic                           r_ev_valid, n_ev_valid;
    logic [pdf_pkg::HANDLE_W-1:0]   r_ev_handle, n_ev_handle;
    logic [pdf_pkg::CNT_W-1:0]      r_flushed, n_flushed;

    // Memory interface.
    logic                           w_in_take;
    logic                           w_wr_en;
    logic [pdf_pkg::HANDLE_W-1:0]   w_head;

    // Effective depth cap.
    logic [pdf_pkg::CMP_W-1:0]      w_cap_sum;
    logic [pdf_pkg::CMP_W-1:0]      w_cap_raw;
    logic [pdf_pkg::CMP_W-1:0]      w_cap;

    // Ring invariant used by the checks.
    logic                           w_ring_ok;

    assign w_in_take   = i_valid && o_ready;
    assign o_ready     = (r_state == pdf_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_cap_sum = pdf_pkg::CMP_W'(r_delay_target) + pdf_pkg::CMP_W'(pdf_pkg::CAP_HEADROOM);
    assign w_cap_raw = (r_depth_cap == '0) ? w_cap_sum : pdf_pkg::CMP_W'(r_depth_cap);
    assign w_cap     = (w_cap_raw > pdf_pkg::CMP_W'(pdf_pkg::RING_SIZE))
                     ? pdf_pkg::CMP_W'(pdf_pkg::RING_SIZE) : w_cap_raw;

    // Entry memory; the head is read when a beat is taken.
    pdf_ram #(
        .DEPTH  (pdf_pkg::RING_SIZE),
        .WIDTH  (pdf_pkg::HANDLE_W),
        .ADDR_W (pdf_pkg::PTR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (r_handle),
        .i_rd_en   (w_in_take),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (w_head)
    );

    // Advances a ring pointer with wrap at the queue depth.
    function automatic logic [pdf_pkg::PTR_W-1:0] advance(input logic [pdf_pkg::PTR_W-1:0] p);
        if (p == pdf_pkg::PTR_W'(pdf_pkg::RING_SIZE - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // Next state and result of the operation in the execute state.
    always_comb begin
        logic go;
        logic evict;
        logic [pdf_pkg::CNT_W-1:0] fill_mid;

        go       = 1'b0;
        evict    = 1'b0;
        fill_mid = r_fill;

        n_state      = r_state;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_fill       = r_fill;
        n_primed     = r_primed;
        n_drops      = r_drops;
        n_underruns  = r_underruns;
        n_pushes     = r_pushes;
        n_out_valid  = r_out_valid && !i_ready;
        n_status     = r_status;
        n_out_handle = r_out_handle;
        n_ev_valid   = r_ev_valid;
        n_ev_handle  = r_ev_handle;
        n_flushed    = r_flushed;
        w_wr_en      = 1'b0;

        case (r_state)
            pdf_pkg::ST_IDLE: begin
                if (w_in_take) begin
                    n_state = pdf_pkg::ST_EXEC;
                end
            end
            pdf_pkg::ST_EXEC: begin
                go = !r_out_valid || i_ready;
            end
            default: begin
                n_state = pdf_pkg::ST_IDLE;
            end
        endcase

        if (go) begin
            n_state      = pdf_pkg::ST_IDLE;
            n_out_valid  = 1'b1;
            n_status     = pdf_pkg::STATUS_OK;
            n_out_handle = '0;
            n_ev_valid   = 1'b0;
            n_ev_handle  = '0;
            n_flushed    = '0;
            case (r_kind)
                pdf_pkg::KIND_PUSH: begin
                    // Drop the oldest entry when the cap is reached.
                    evict = (pdf_pkg::CMP_W'(r_fill) >= w_cap) && (r_fill != '0);
                    if (evict) begin
                        n_ev_valid  = 1'b1;
                        n_ev_handle = w_head;
                        n_rd_ptr    = advance(r_rd_ptr);
                        n_drops     = r_drops + 32'd1;
                        fill_mid    = r_fill - 1'b1;
                    end
                    n_fill = fill_mid;
                    if (pdf_pkg::CMP_W'(fill_mid) < pdf_pkg::CMP_W'(pdf_pkg::RING_SIZE)) begin
                        w_wr_en  = 1'b1;
                        n_wr_ptr = advance(r_wr_ptr);
                        n_fill   = fill_mid + 1'b1;
                        n_pushes = r_pushes + 32'd1;
                        if (pdf_pkg::CMP_W'(fill_mid) + 1'b1 >= pdf_pkg::CMP_W'(r_delay_target)) begin
                            n_primed = 1'b1;
                        end
                    end
                end
                pdf_pkg::KIND_POP: begin
                    if (!r_primed) begin
                        n_status = pdf_pkg::STATUS_NOT_PRIMED;
                    end else if (r_fill == '0) begin
                        n_status    = pdf_pkg::STATUS_UNDERRUN;
                        n_underruns = r_underruns + 32'd1;
                        n_primed    = 1'b0;
                    end else begin
                        n_out_handle = w_head;
                        n_rd_ptr     = advance(r_rd_ptr);
                        n_fill       = r_fill - 1'b1;
                    end
                end
                pdf_pkg::KIND_FLUSH: begin
                    n_flushed = r_fill;
                    n_fill    = '0;
                    n_rd_ptr  = '0;
                    n_wr_ptr  = '0;
                    n_primed  = 1'b0;
                end
                default: begin
                    // Unused code: state is left as it is.
                end
            endcase
        end
    end

    // Control and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= pdf_pkg::ST_IDLE;
            r_rd_ptr       <= '0;
            r_wr_ptr       <= '0;
            r_fill         <= '0;
            r_primed       <= 1'b0;
            r_drops        <= '0;
            r_underruns    <= '0;
            r_pushes       <= '0;
            r_out_valid    <= 1'b0;
            r_delay_target <= pdf_pkg::DELAY_TARGET_RESET;
            r_depth_cap    <= '0;
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_fill      <= n_fill;
            r_primed    <= n_primed;
            r_drops     <= n_drops;
            r_underruns <= n_underruns;
            r_pushes    <= n_pushes;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == pdf_pkg::REG_DELAY_TARGET) begin
                    r_delay_target <= i_cfg_data;
                end else if (i_cfg_index == pdf_pkg::REG_DEPTH_CAP) begin
                    r_depth_cap <= i_cfg_data;
                end
            end
        end
    end

    // Payload registers: captured beat and result fields.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_kind   <= i_kind;
            r_handle <= i_block_handle;
        end
        r_status     <= n_status;
        r_out_handle <= n_out_handle;
        r_ev_valid   <= n_ev_valid;
        r_ev_handle  <= n_ev_handle;
        r_flushed    <= n_flushed;
    end

    // Result beat; depth, flag and totals are the state after the operation.
    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_out_handle     = r_out_handle;
    assign o_evicted_valid  = r_ev_valid;
    assign o_evicted_handle = r_ev_handle;
    assign o_fill_level     = r_fill;
    assign o_is_primed      = r_primed;
    assign o_flushed_count  = r_flushed;
    assign o_dropped_total  = r_drops;
    assign o_underrun_total = r_underruns;
    assign o_pushed_total   = r_pushes;

    // While idle the write pointer leads the read pointer by the fill.
    assign w_ring_ok = (r_state != pdf_pkg::ST_IDLE)
                    || (pdf_pkg::PTR_W'(r_rd_ptr + r_fill) == r_wr_ptr)
                    || (pdf_pkg::RING_SIZE != (1 << pdf_pkg::PTR_W));

    // Checks on the ring state and the sequencer.
`include "assert_macros.svh"
    `ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= pdf_pkg::CNT_W'(pdf_pkg::RING_SIZE))
    `ASSERT_ALWAYS(a_ring_consistent, i_clk, i_rst_n, w_ring_ok)
    `ASSERT_NEXT(a_take_blocks, i_clk, i_rst_n, w_in_take, !o_ready)
    `ASSERT_NEXT(a_exec_done, i_clk, i_rst_n, (r_state == pdf_pkg::ST_EXEC) && (!r_out_valid || i_ready), o_valid && o_ready)

endmodule

FILE: tb/pdf_op_checker.sv
// Checker for the priming delay FIFO: predicts each operation and compares result beats.
module pdf_op_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Operation channel.
    input  logic                            i_op_valid,
    input  logic                            i_op_ready,
    input  logic [1:0]                      i_kind,
    input  logic [pdf_pkg::HANDLE_W-1:0]    i_block_handle,
    // Result channel.
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic [1:0]                      i_status,
    input  logic [pdf_pkg::HANDLE_W-1:0]    i_out_handle,
    input  logic                            i_evicted_valid,
    input  logic [pdf_pkg::HANDLE_W-1:0]    i_evicted_handle,
    input  logic [pdf_pkg::CNT_W-1:0]       i_fill_level,
    input  logic                            i_is_primed,
    input  logic [pdf_pkg::CNT_W-1:0]       i_flushed_count,
    input  logic [31:0]                     i_dropped_total,
    input  logic [31:0]                     i_underrun_total,
    input  logic [31:0]                     i_pushed_total,
    // Register write channel.
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [pdf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pdf_pkg::CFG_W-1:0]       i_cfg_data,
    // Status toward the testbench top.
    output int                              o_fail_count,
    output int                              o_pending
);

    typedef struct packed {
        logic [1:0]                   status;
        logic [pdf_pkg::HANDLE_W-1:0] out_handle;
        logic                         evicted_valid;
        logic [pdf_pkg::HANDLE_W-1:0] evicted_handle;
        logic [pdf_pkg::CNT_W-1:0]    fill_level;
        logic                         is_primed;
        logic [pdf_pkg::CNT_W-1:0]    flushed_count;
        logic [31:0]                  dropped_total;
        logic [31:0]                  underrun_total;
        logic [31:0]                  pushed_total;
    } t_fifo_result;

    // Shadow copy of the ring, its pointers, flags, counters and registers.
    logic [pdf_pkg::HANDLE_W-1:0] ring [pdf_pkg::RING_SIZE];
    logic [pdf_pkg::PTR_W-1:0]    rd_ptr;
    logic [pdf_pkg::PTR_W-1:0]    wr_ptr;
    int                           fill;
    logic                         primed;
    logic [31:0]                  drop_cnt;
    logic [31:0]                  underrun_cnt;
    logic [31:0]                  push_cnt;
    logic [pdf_pkg::CFG_W-1:0]    delay_target;
    logic [pdf_pkg::CFG_W-1:0]    depth_cap;

    t_fifo_result                 pending_results[$];
    t_fifo_result                 want;
    t_fifo_result                 got;
    int                           mismatches = 0;
    int                           outstanding = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = outstanding;

    function automatic logic [pdf_pkg::PTR_W-1:0] next_slot(input logic [pdf_pkg::PTR_W-1:0] p);
        return (int'(p) == pdf_pkg::RING_SIZE - 1) ? '0 : p + 1'b1;
    endfunction

    // Applies one operation to the shadow state and returns the result it should produce.
    task automatic apply_fifo_op(input logic [1:0] kind,
                                 input logic [pdf_pkg::HANDLE_W-1:0] handle,
                                 output t_fifo_result res);
        int cap;
        res = '0;
        cap = (depth_cap == '0) ? int'(delay_target) + pdf_pkg::CAP_HEADROOM
                                : int'(depth_cap);
        if (cap > pdf_pkg::RING_SIZE) begin
            cap = pdf_pkg::RING_SIZE;
        end
        case (kind)
            pdf_pkg::KIND_PUSH: begin
                // Drop the oldest entry when the queue sits at or above its cap.
                if (fill >= cap && fill > 0) begin
                    res.evicted_valid  = 1'b1;
                    res.evicted_handle = ring[rd_ptr];
                    rd_ptr             = next_slot(rd_ptr);
                    fill--;
                    drop_cnt++;
                end
                if (fill < pdf_pkg::RING_SIZE) begin
                    ring[wr_ptr] = handle;
                    wr_ptr       = next_slot(wr_ptr);
                    fill++;
                    push_cnt++;
                    if (fill >= int'(delay_target)) begin
                        primed = 1'b1;
                    end
                end
            end
            pdf_pkg::KIND_POP: begin
                if (!primed) begin
                    res.status = pdf_pkg::STATUS_NOT_PRIMED;
                end else if (fill == 0) begin
                    res.status = pdf_pkg::STATUS_UNDERRUN;
                    underrun_cnt++;
                    primed = 1'b0;
                end else begin
                    res.out_handle = ring[rd_ptr];
                    rd_ptr         = next_slot(rd_ptr);
                    fill--;
                end
            end
            pdf_pkg::KIND_FLUSH: begin
                res.flushed_count = pdf_pkg::CNT_W'(fill);
                fill   = 0;
                rd_ptr = '0;
                wr_ptr = '0;
                primed = 1'b0;
            end
            default: begin
                // The spare code leaves everything as it is.
            end
        endcase
        res.fill_level     = pdf_pkg::CNT_W'(fill);
        res.is_primed      = primed;
        res.dropped_total  = drop_cnt;
        res.underrun_total = underrun_cnt;
        res.pushed_total   = push_cnt;
    endtask

    task automatic check_field(input string label, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, label, exp_v, act_v);
        end
    endtask

    // Watch all three channels at every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_ptr       = '0;
            wr_ptr       = '0;
            fill         = 0;
            primed       = 1'b0;
            drop_cnt     = '0;
            underrun_cnt = '0;
            push_cnt     = '0;
            delay_target = pdf_pkg::DELAY_TARGET_RESET;
            depth_cap    = '0;
            pending_results.delete();
        end else begin
            // Compare a result beat with the oldest prediction.
            if (i_res_valid && i_res_ready) begin
                got = '{i_status, i_out_handle, i_evicted_valid, i_evicted_handle,
                        i_fill_level, i_is_primed, i_flushed_count, i_dropped_total,
                        i_underrun_total, i_pushed_total};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with no operation outstanding", $time);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("out_handle", want.out_handle, got.out_handle);
                    check_field("evicted_valid", 32'(want.evicted_valid),
                                32'(got.evicted_valid));
                    check_field("evicted_handle", want.evicted_handle, got.evicted_handle);
                    check_field("fill_level", 32'(want.fill_level), 32'(got.fill_level));
                    check_field("is_primed", 32'(want.is_primed), 32'(got.is_primed));
                    check_field("flushed_count", 32'(want.flushed_count),
                                32'(got.flushed_count));
                    check_field("dropped_total", want.dropped_total, got.dropped_total);
                    check_field("underrun_total", want.underrun_total, got.underrun_total);
                    check_field("pushed_total", want.pushed_total, got.pushed_total);
                end
            end
            // The testbench writes registers only while the block is idle; the block itself does not enforce this.
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == pdf_pkg::REG_DELAY_TARGET) begin
                    delay_target = i_cfg_data;
                end else if (i_cfg_index == pdf_pkg::REG_DEPTH_CAP) begin
                    depth_cap = i_cfg_data;
                end
            end
            // Predict the result of each accepted operation beat.
            if (i_op_valid && i_op_ready) begin
                apply_fifo_op(i_kind, i_block_handle, want);
                pending_results.push_back(want);
            end
        end
        outstanding = pending_results.size();
    end

endmodule

FILE: tb/priming_delay_fifo_core_tb.sv
// Testbench top for the priming delay FIFO: clock, reset, stimulus and final verdict.
module priming_delay_fifo_core_tb;

    localparam logic [1:0]                    KIND_SPARE     = 2'd3;
    localparam logic [pdf_pkg::CFG_IDX_W-1:0] REG_SPARE      = 2'd3;
    localparam int                            RANDOM_ITEMS   = 1800;
    localparam int                            PHASE_ITEMS    = 100;
    localparam int                            FIXED_PHASES   = 6;
    localparam int                            HOLD_PHASE     = 5;
    localparam int                            RX_HOLD_CYCLES = 300;
    localparam int                            TIMEOUT_UNITS  = 4_000_000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [1:0]                     i_kind;
    logic [pdf_pkg::HANDLE_W-1:0]   i_block_handle;
    logic                           o_valid;
    logic                           i_ready;
    logic [1:0]                     o_status;
    logic [pdf_pkg::HANDLE_W-1:0]   o_out_handle;
    logic                           o_evicted_valid;
    logic [pdf_pkg::HANDLE_W-1:0]   o_evicted_handle;
    logic [pdf_pkg::CNT_W-1:0]      o_fill_level;
    logic                           o_is_primed;
    logic [pdf_pkg::CNT_W-1:0]      o_flushed_count;
    logic [31:0]                    o_dropped_total;
    logic [31:0]                    o_underrun_total;
    logic [31:0]                    o_pushed_total;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [pdf_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [pdf_pkg::CFG_W-1:0]      i_cfg_data;

    int                    fail_count;
    int                    pending;
    bit                    steady_flow = 1'b0;
    bit                    rx_hold_req = 1'b0;

    // Register settings for the first phases: saturation, full cap, cap below fill, extremes.
    int                    target_list [FIXED_PHASES] = '{127, 64, 4, 0, 1, 63};
    int                    cap_list    [FIXED_PHASES] = '{0, 64, 1, 2, 127, 0};

    priming_delay_fifo_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_block_handle   (i_block_handle),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_out_handle     (o_out_handle),
        .o_evicted_valid  (o_evicted_valid),
        .o_evicted_handle (o_evicted_handle),
        .o_fill_level     (o_fill_level),
        .o_is_primed      (o_is_primed),
        .o_flushed_count  (o_flushed_count),
        .o_dropped_total  (o_dropped_total),
        .o_underrun_total (o_underrun_total),
        .o_pushed_total   (o_pushed_total),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    pdf_op_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op_valid       (i_valid),
        .i_op_ready       (o_ready),
        .i_kind           (i_kind),
        .i_block_handle   (i_block_handle),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_status         (o_status),
        .i_out_handle     (o_out_handle),
        .i_evicted_valid  (o_evicted_valid),
        .i_evicted_handle (o_evicted_handle),
        .i_fill_level     (o_fill_level),
        .i_is_primed      (o_is_primed),
        .i_flushed_count  (o_flushed_count),
        .i_dropped_total  (o_dropped_total),
        .i_underrun_total (o_underrun_total),
        .i_pushed_total   (o_pushed_total),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Clock with a period of two units.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle gap lengths: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        if (steady_flow) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Presents one operation beat, waits for it to be taken, then idles for a random gap.
    task automatic send_op(input logic [1:0] kind, input logic [pdf_pkg::HANDLE_W-1:0] handle);
        int g;
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_block_handle <= handle;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        g = gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    // Stops offering beats and waits until every predicted result has come back.
    task automatic drain_block();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [pdf_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= pdf_pkg::CFG_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_reg_value();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 64;
            3: return 127;
            default: return $urandom_range(0, 127);
        endcase
    endfunction

    // Result side: random stalls, plus one long hold-off when asked.
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    // Run limit.
    initial begin
        #(TIMEOUT_UNITS);
        $display("** priming_delay_fifo_core: FAILED **");
        $finish;
    end

    // Main stimulus.
    initial begin
        int       phase;
        int       done_items;
        int       n;
        int       r;
        int       push_pct;
        int       tgt_v;
        int       cap_v;
        logic [1:0] kind;

        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_kind         = pdf_pkg::KIND_PUSH;
        i_block_handle = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = pdf_pkg::REG_DELAY_TARGET;
        i_cfg_data     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset register values (target four, cap fourteen).
        send_op(pdf_pkg::KIND_POP, '0);             // pop before priming on an empty queue
        send_op(KIND_SPARE, '1);                    // spare code changes nothing
        send_op(pdf_pkg::KIND_FLUSH, '0);           // flush with nothing held
        send_op(pdf_pkg::KIND_PUSH, 32'h0000_0000);
        send_op(pdf_pkg::KIND_PUSH, 32'hFFFF_FFFF);
        send_op(pdf_pkg::KIND_PUSH, 32'h5A5A_5A5A);
        send_op(pdf_pkg::KIND_PUSH, 32'hA5A5_A5A5); // fourth push primes
        repeat (4) send_op(pdf_pkg::KIND_POP, $urandom());
        send_op(pdf_pkg::KIND_POP, '0);             // underrun, clears primed
        send_op(pdf_pkg::KIND_POP, '0);             // not primed again
        repeat (3) send_op(pdf_pkg::KIND_PUSH, $urandom());
        send_op(pdf_pkg::KIND_POP, '0);             // three held, still below target
        send_op(pdf_pkg::KIND_FLUSH, '1);           // discards three
        repeat (2) send_op(pdf_pkg::KIND_PUSH, $urandom());

        // Random phases, each under its own register setting.
        phase      = 0;
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            drain_block();
            if (phase < FIXED_PHASES) begin
                tgt_v = target_list[phase];
                cap_v = cap_list[phase];
            end else begin
                tgt_v = pick_reg_value();
                cap_v = pick_reg_value();
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(pdf_pkg::REG_DEPTH_CAP, cap_v);
                write_reg(pdf_pkg::REG_DELAY_TARGET, tgt_v);
            end else begin
                write_reg(pdf_pkg::REG_DELAY_TARGET, tgt_v);
                write_reg(pdf_pkg::REG_DEPTH_CAP, cap_v);
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_SPARE, $urandom_range(0, 127));
            end

            case ($urandom_range(0, 3))
                0: push_pct = 35;
                1: push_pct = 55;
                2: push_pct = 75;
                default: push_pct = 95;
            endcase
            if (phase < 2) begin
                push_pct = 95;
            end
            steady_flow = ($urandom_range(0, 3) == 0);

            // One phase runs against a long result hold-off so the block backs up.
            if (phase == HOLD_PHASE) begin
                steady_flow = 1'b1;
                rx_hold_req = 1'b1;
            end

            n = 0;
            while (n < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    kind = KIND_SPARE;
                end else if (r < 5) begin
                    kind = pdf_pkg::KIND_FLUSH;
                end else if (r < 5 + (push_pct * 95) / 100) begin
                    kind = pdf_pkg::KIND_PUSH;
                end else begin
                    kind = pdf_pkg::KIND_POP;
                end
                send_op(kind, $urandom());
                if (kind != KIND_SPARE) begin
                    n++;
                end
                // Now and then the sender waits for every result before going on.
                if ($urandom_range(0, 149) == 0) begin
                    drain_block();
                end
            end
            steady_flow = 1'b0;
            done_items += PHASE_ITEMS;
            phase++;
        end

        drain_block();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** priming_delay_fifo_core: PASSED **");
        end else begin
            $display("** priming_delay_fifo_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: priming_delay_fifo_core.f
+incdir+hw/rtl
hw/rtl/pdf_pkg.sv
hw/rtl/pdf_ram.sv
hw/rtl/priming_delay_fifo_core.sv
tb/pdf_op_checker.sv
tb/priming_delay_fifo_core_tb.sv
